// File: src/assert_macros.svh
// Assertion macros for the checker of the lag accumulator.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define MSDLA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("msdla assertion failed");

// Clocked assertion that is also checked during reset.
`define MSDLA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("msdla assertion failed");

`endif

// File: src/msdla_pkg.sv
// Shared types and constants of the lag accumulator.
// Used by the channel interfaces, the core and the checker; no dependencies.
package msdla_pkg;

  localparam int KIND_W = 2;
  localparam int POS_W  = 12;
  localparam int LAG_W  = 10;
  localparam int SUM_W  = 48;
  localparam int CNT_W  = 11;
  localparam int FS_W   = 11;
  localparam int SQ_W   = 2 * (POS_W + 1);
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_ACCUM = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic {
    REG_SPACING_MODE  = 1'b0,
    REG_FIXED_SPACING = 1'b1
  } reg_idx_e;

endpackage

// File: src/msdla_if.sv
// Valid/ready channel interfaces of the lag accumulator: input items and results.
// Depends on msdla_pkg for the field widths.
interface msdla_in_if;
  logic                               valid;
  logic                               ready;
  logic [msdla_pkg::KIND_W-1:0]       kind;
  logic signed [msdla_pkg::POS_W-1:0] position;
  logic [msdla_pkg::LAG_W-1:0]        lag;

  modport source (output valid, kind, position, lag, input ready);
  modport sink   (input valid, kind, position, lag, output ready);
endinterface

interface msdla_out_if;
  logic                         valid;
  logic                         ready;
  logic [msdla_pkg::SUM_W-1:0]  lag_sum;
  logic [msdla_pkg::CNT_W-1:0]  origin_count;
  logic                         sum_saturated;

  modport source (output valid, lag_sum, origin_count, sum_saturated, input ready);
  modport sink   (input valid, lag_sum, origin_count, sum_saturated, output ready);
endinterface

// File: src/msd_lag_accumulator_core.sv
// Lag accumulator core: squared-displacement sums per lag over loaded trajectories.
// Depends on msdla_pkg and the channel interfaces in msdla_if.sv.
//
// A load transaction stores one clamped position; loads stream at one per cycle
// while the result channel is not stalled. A read transaction reads both memories,
// registers its result in the READ state and then presents it. An accumulate
// transaction runs a sequencer over every lag of the loaded trajectory, with a
// single subtract-square-add unit fed by two read ports of the trajectory memory:
// each lag passes LAG_RD and LAG_LD, then ORG_RD, ORG_MUL and ORG_ADD per origin,
// then LAG_WR, and the core takes no input meanwhile. After reset the sum memory
// is cleared before the first transaction is accepted; configuration writes are
// taken at any time. Lags at or beyond the length of the last accumulated
// trajectory read back an origin count of zero.
module msd_lag_accumulator_core #(
  parameter int MAX_SAMPLES    = 1024,
  parameter int POSITION_BOUND = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  msdla_in_if.sink                           in_i,
  msdla_out_if.source                        out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [msdla_pkg::ADDR_W-1:0]       paddr,
  input  logic [msdla_pkg::DATA_W-1:0]       pwdata,
  output logic [msdla_pkg::DATA_W-1:0]       prdata,
  output logic                               pready
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = (AW > msdla_pkg::FS_W) ? AW : msdla_pkg::FS_W;
  localparam int NW = ((CW > SW) ? CW : SW) + 1;
  localparam int XW = ((AW > msdla_pkg::LAG_W) ? AW : msdla_pkg::LAG_W) + 1;
  localparam int PW = msdla_pkg::POS_W;
  localparam int MW = msdla_pkg::SUM_W + 1;

  localparam logic signed [31:0] PB_HI = 32'(POSITION_BOUND);
  localparam logic signed [31:0] PB_LO = -32'(POSITION_BOUND);

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_READ    = 4'd2;
  localparam logic [3:0] ST_LAG_RD  = 4'd3;
  localparam logic [3:0] ST_LAG_LD  = 4'd4;
  localparam logic [3:0] ST_ORG_RD  = 4'd5;
  localparam logic [3:0] ST_ORG_MUL = 4'd6;
  localparam logic [3:0] ST_ORG_ADD = 4'd7;
  localparam logic [3:0] ST_LAG_WR  = 4'd8;

  // Memories
  logic signed [PW-1:0]              traj_mem [MAX_SAMPLES];
  logic [MW-1:0]                     sum_mem  [MAX_SAMPLES];
  logic [msdla_pkg::CNT_W-1:0]       cnt_mem  [MAX_SAMPLES];

  // Control registers
  logic [3:0]                        state_q, state_d;
  logic [CW-1:0]                     len_q, len_d;
  logic [CW-1:0]                     last_len_q, last_len_d;
  logic [AW-1:0]                     clr_q, clr_d;
  logic                              out_valid_q, out_valid_d;
  logic                              spacing_mode_q;
  logic [msdla_pkg::FS_W-1:0]        fixed_spacing_q;

  // Datapath registers
  logic [AW-1:0]                     lag_q, org_q, hi_q;
  logic [CW-1:0]                     oc_q;
  logic [msdla_pkg::SUM_W-1:0]       acc_q;
  logic                              sat_q;
  logic [msdla_pkg::SQ_W-1:0]        sq_q;
  logic signed [PW-1:0]              ta_q, tb_q;
  logic [MW-1:0]                     sum_rd_q;
  logic [msdla_pkg::CNT_W-1:0]       cnt_rd_q;
  logic                              rd_ok_q, rd_cnt_ok_q;
  logic [msdla_pkg::SUM_W-1:0]       out_sum_q;
  logic [msdla_pkg::CNT_W-1:0]       out_cnt_q;
  logic                              out_sat_q;

  // Combinational
  logic                              in_ready;
  logic                              in_acc;
  logic                              is_load, is_accum, is_read;
  logic [XW-1:0]                     rd_lag_ext;
  logic [AW-1:0]                     rd_addr;
  logic [AW-1:0]                     sum_raddr;
  logic                              sum_we;
  logic [AW-1:0]                     sum_waddr;
  logic [MW-1:0]                     sum_wdata;
  logic                              cnt_we;
  logic [msdla_pkg::CNT_W-1:0]       cnt_wdata;
  logic                              traj_we;
  logic signed [31:0]                pos_ext;
  logic signed [PW-1:0]              pos_clamped;
  logic [SW-1:0]                     step;
  logic [NW-1:0]                     hi_next;
  logic                              org_more;
  logic                              lag_last;
  logic signed [PW:0]                diff;
  logic signed [2*PW+1:0]            prod;
  logic [MW-1:0]                     acc_sum;
  logic                              cfg_we;

  // Handshake
  assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_acc   = in_i.valid && in_ready;
  assign is_load  = in_acc && (in_i.kind == msdla_pkg::KIND_LOAD);
  assign is_accum = in_acc && (in_i.kind == msdla_pkg::KIND_ACCUM);
  assign is_read  = in_acc && (in_i.kind == msdla_pkg::KIND_READ);

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.lag_sum       = out_sum_q;
  assign out_o.origin_count  = out_cnt_q;
  assign out_o.sum_saturated = out_sat_q;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    unique case (msdla_pkg::reg_idx_e'(paddr[2]))
      msdla_pkg::REG_SPACING_MODE:  prdata = msdla_pkg::DATA_W'(spacing_mode_q);
      msdla_pkg::REG_FIXED_SPACING: prdata = msdla_pkg::DATA_W'(fixed_spacing_q);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_mode_q  <= 1'b0;
      fixed_spacing_q <= msdla_pkg::FS_W'(1);
    end else if (cfg_we) begin
      unique case (msdla_pkg::reg_idx_e'(paddr[2]))
        msdla_pkg::REG_SPACING_MODE:  spacing_mode_q  <= pwdata[0];
        msdla_pkg::REG_FIXED_SPACING: fixed_spacing_q <= pwdata[msdla_pkg::FS_W-1:0];
        default: ;
      endcase
    end
  end

  // Position clamp
  assign pos_ext = 32'(in_i.position);
  always_comb begin
    priority if (pos_ext > PB_HI) begin
      pos_clamped = PW'(PB_HI);
    end else if (pos_ext < PB_LO) begin
      pos_clamped = PW'(PB_LO);
    end else begin
      pos_clamped = in_i.position;
    end
  end

  // Read addressing
  assign rd_lag_ext = XW'(in_i.lag);
  assign rd_addr    = rd_lag_ext[AW-1:0];

  // Origin stepping
  always_comb begin
    if (spacing_mode_q) begin
      step = (fixed_spacing_q == '0) ? SW'(1) : SW'(fixed_spacing_q);
    end else begin
      step = (lag_q == '0) ? SW'(1) : SW'(lag_q);
    end
  end
  assign hi_next  = NW'(hi_q) + NW'(step);
  assign org_more = hi_next < NW'(len_q);
  assign lag_last = (NW'(lag_q) + NW'(1)) == NW'(len_q);

  // Shared subtract-square-accumulate unit
  assign diff    = (PW + 1)'(ta_q) - (PW + 1)'(tb_q);
  assign prod    = diff * diff;
  assign acc_sum = {1'b0, acc_q} + MW'(sq_q);

  // Memory port control
  assign sum_raddr = (state_q == ST_IDLE) ? rd_addr : lag_q;
  assign traj_we   = is_load && (len_q < CW'(MAX_SAMPLES));
  assign cnt_we    = (state_q == ST_LAG_WR);
  assign cnt_wdata = (32'(oc_q) > 32'(msdla_pkg::CNT_MAX)) ? msdla_pkg::CNT_MAX
                                                           : msdla_pkg::CNT_W'(oc_q);

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = lag_q;
    sum_wdata = {sat_q, acc_q};
    if (state_q == ST_CLEAR) begin
      sum_we    = 1'b1;
      sum_waddr = clr_q;
      sum_wdata = '0;
    end else if (state_q == ST_LAG_WR) begin
      sum_we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (traj_we) begin
      traj_mem[len_q[AW-1:0]] <= pos_clamped;
    end
    ta_q <= traj_mem[hi_q];
    tb_q <= traj_mem[org_q];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_rd_q <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[lag_q] <= cnt_wdata;
    end
    cnt_rd_q <= cnt_mem[rd_addr];
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    last_len_d  = last_len_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(MAX_SAMPLES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (traj_we) begin
          len_d = len_q + CW'(1);
        end
        if (is_accum) begin
          state_d = ST_LAG_RD;
        end else if (is_read) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_LAG_RD: begin
        if (len_q == '0) begin
          // nothing loaded: make every origin count read back as zero and finish
          last_len_d = '0;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_LAG_LD;
        end
      end
      ST_LAG_LD:  state_d = ST_ORG_RD;
      ST_ORG_RD:  state_d = ST_ORG_MUL;
      ST_ORG_MUL: state_d = ST_ORG_ADD;
      ST_ORG_ADD: state_d = org_more ? ST_ORG_RD : ST_LAG_WR;
      ST_LAG_WR: begin
        if (lag_last) begin
          last_len_d = len_q;
          len_d      = '0;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_LAG_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      len_q       <= '0;
      last_len_q  <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      last_len_q  <= last_len_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        lag_q       <= '0;
        rd_ok_q     <= rd_lag_ext < XW'(MAX_SAMPLES);
        rd_cnt_ok_q <= rd_lag_ext < XW'(last_len_q);
      end
      ST_READ: begin
        out_sum_q <= rd_ok_q ? sum_rd_q[msdla_pkg::SUM_W-1:0] : '0;
        out_sat_q <= rd_ok_q && sum_rd_q[msdla_pkg::SUM_W];
        out_cnt_q <= rd_cnt_ok_q ? cnt_rd_q : '0;
      end
      ST_LAG_LD: begin
        acc_q <= sum_rd_q[msdla_pkg::SUM_W-1:0];
        sat_q <= sum_rd_q[msdla_pkg::SUM_W];
        org_q <= '0;
        hi_q  <= lag_q;
        oc_q  <= '0;
      end
      ST_ORG_MUL: begin
        sq_q <= msdla_pkg::SQ_W'(unsigned'(prod));
      end
      ST_ORG_ADD: begin
        // hold at the maximum and flag the lag on overflow
        if (acc_sum[msdla_pkg::SUM_W]) begin
          acc_q <= msdla_pkg::SUM_MAX;
          sat_q <= 1'b1;
        end else begin
          acc_q <= acc_sum[msdla_pkg::SUM_W-1:0];
        end
        oc_q <= oc_q + CW'(1);
        if (org_more) begin
          hi_q  <= hi_next[AW-1:0];
          org_q <= AW'(NW'(org_q) + NW'(step));
        end
      end
      ST_LAG_WR: begin
        lag_q <= lag_q + AW'(1);
      end
      default: ;
    endcase
  end

endmodule

// File: src/msdla_checker.sv
// Port-level checker for the lag accumulator core, attached by bind.
// Depends on msdla_pkg and assert_macros.svh.
`include "assert_macros.svh"

module msdla_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [msdla_pkg::KIND_W-1:0]  in_kind_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [msdla_pkg::SUM_W-1:0]   out_lag_sum_i,
  input logic [msdla_pkg::CNT_W-1:0]   out_origin_count_i,
  input logic                          out_sum_saturated_i
);

  logic in_read, in_accum;

  assign in_read  = in_valid_i && in_ready_i && (in_kind_i == msdla_pkg::KIND_READ);
  assign in_accum = in_valid_i && in_ready_i && (in_kind_i == msdla_pkg::KIND_ACCUM);

  // a stalled result holds its payload
  `MSDLA_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_lag_sum_i) && $stable(out_origin_count_i) && $stable(out_sum_saturated_i))

  // every read transaction produces a result once its READ state has passed
  `MSDLA_ASSERT(a_read_latency, in_read |=> ##1 out_valid_i)

  // a fresh result always comes from an accepted read
  `MSDLA_ASSERT(a_no_spurious_result, $rose(out_valid_i) |-> $past(in_read, 2))

  // the sequencer owns the core once an accumulate is taken
  `MSDLA_ASSERT(a_accum_busy, in_accum |=> !in_ready_i)

  // a saturated lag always reads back at the ceiling
  `MSDLA_ASSERT(a_sat_at_max, out_valid_i && out_sum_saturated_i |-> out_lag_sum_i == msdla_pkg::SUM_MAX)

endmodule

bind msd_lag_accumulator_core msdla_checker u_msdla_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .in_kind_i           (in_i.kind),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_lag_sum_i       (out_o.lag_sum),
  .out_origin_count_i  (out_o.origin_count),
  .out_sum_saturated_i (out_o.sum_saturated)
);

// File: tb/msdla_checker.sv
`timescale 1ns / 1ps
// Checker for the lag accumulator: watches both channels and the APB writes,
// predicts every lag reading and compares it. Depends on msdla_pkg and msdla_if.sv.
module msdla_scoreboard #(
  parameter int MAX_SAMPLES    = 1024,
  parameter int POSITION_BOUND = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  msdla_in_if                            in_mon,
  msdla_out_if                           out_mon,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [msdla_pkg::ADDR_W-1:0]   paddr,
  input  logic [msdla_pkg::DATA_W-1:0]   pwdata,
  output int                             mismatches,
  output int                             pending
);

  typedef struct packed {
    logic [msdla_pkg::SUM_W-1:0] lag_sum;
    logic [msdla_pkg::CNT_W-1:0] origin_count;
    logic                        sum_saturated;
  } lag_reading_t;

  lag_reading_t                readings_due[$];
  lag_reading_t                want;

  int                          track [MAX_SAMPLES];
  int                          track_len;
  logic [msdla_pkg::SUM_W-1:0] sum_by_lag [MAX_SAMPLES];
  int                          origins_by_lag [MAX_SAMPLES];
  logic                        saturated_by_lag [MAX_SAMPLES];
  logic                        fixed_step_mode;
  logic [msdla_pkg::FS_W-1:0]  fixed_step;

  task automatic report_mismatch(input string what);
    if (mismatches < 50) $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic int clamp_position(input logic signed [msdla_pkg::POS_W-1:0] raw);
    int v;
    v = raw;
    if (v > POSITION_BOUND) v = POSITION_BOUND;
    if (v < -POSITION_BOUND) v = -POSITION_BOUND;
    return v;
  endfunction

  // Walk every lag of the loaded trajectory, then start a new history.
  task automatic fold_history();
    int                        step;
    int                        d;
    logic [msdla_pkg::SUM_W:0] total;
    for (int i = 0; i < MAX_SAMPLES; i++) origins_by_lag[i] = 0;
    for (int lag = 0; lag < track_len; lag++) begin
      if (fixed_step_mode) step = (fixed_step == '0) ? 1 : int'(fixed_step);
      else step = (lag == 0) ? 1 : lag;
      for (int org = 0; org < track_len - lag; org += step) begin
        d = track[org + lag] - track[org];
        total = {1'b0, sum_by_lag[lag]} + (msdla_pkg::SUM_W+1)'(d * d);
        if (total > {1'b0, msdla_pkg::SUM_MAX}) begin
          sum_by_lag[lag] = msdla_pkg::SUM_MAX;
          saturated_by_lag[lag] = 1'b1;
        end else begin
          sum_by_lag[lag] = total[msdla_pkg::SUM_W-1:0];
        end
        origins_by_lag[lag]++;
      end
    end
    track_len = 0;
  endtask

  function automatic lag_reading_t lag_reading(input logic [msdla_pkg::LAG_W-1:0] lag);
    lag_reading_t r;
    r = '0;
    if (int'(lag) < MAX_SAMPLES) begin
      r.lag_sum = sum_by_lag[lag];
      r.origin_count = (origins_by_lag[lag] > msdla_pkg::CNT_MAX)
                       ? msdla_pkg::CNT_MAX : msdla_pkg::CNT_W'(origins_by_lag[lag]);
      r.sum_saturated = saturated_by_lag[lag];
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SAMPLES; i++) begin
        sum_by_lag[i] = '0;
        origins_by_lag[i] = 0;
        saturated_by_lag[i] = 1'b0;
      end
      track_len = 0;
      fixed_step_mode = 1'b0;
      fixed_step = msdla_pkg::FS_W'(1);
      readings_due.delete();
      mismatches = 0;
      pending = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (readings_due.size() == 0) begin
          report_mismatch("result transaction with no read outstanding");
        end else begin
          want = readings_due.pop_front();
          if (out_mon.lag_sum !== want.lag_sum)
            report_mismatch($sformatf("lag_sum %0d, expected %0d",
                                      out_mon.lag_sum, want.lag_sum));
          if (out_mon.origin_count !== want.origin_count)
            report_mismatch($sformatf("origin_count %0d, expected %0d",
                                      out_mon.origin_count, want.origin_count));
          if (out_mon.sum_saturated !== want.sum_saturated)
            report_mismatch($sformatf("sum_saturated %0b, expected %0b",
                                      out_mon.sum_saturated, want.sum_saturated));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        unique case (msdla_pkg::kind_e'(in_mon.kind))
          msdla_pkg::KIND_LOAD: begin
            // drop loads once the trajectory is full
            if (track_len < MAX_SAMPLES) begin
              track[track_len] = clamp_position(in_mon.position);
              track_len++;
            end
          end
          msdla_pkg::KIND_ACCUM: fold_history();
          msdla_pkg::KIND_READ:
            readings_due.insert(readings_due.size(), lag_reading(in_mon.lag));
          default: ;
        endcase
      end
      if (psel && penable && pwrite && pready) begin
        unique case (msdla_pkg::reg_idx_e'(paddr[2]))
          msdla_pkg::REG_SPACING_MODE:  fixed_step_mode = pwdata[0];
          msdla_pkg::REG_FIXED_SPACING: fixed_step = pwdata[msdla_pkg::FS_W-1:0];
          default: ;
        endcase
      end
      pending = readings_due.size();
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for msd_lag_accumulator_core: drives trajectories, accumulates,
// reads and APB writes with random gaps; msdla_scoreboard does the prediction.
module tb_top;

  localparam int MAX_SAMPLES     = 1024;
  localparam int POSITION_BOUND  = 1024;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int ITEM_TARGET     = 1650;
  localparam int POS_TOP         = 2 ** (msdla_pkg::POS_W - 1) - 1;
  localparam int POS_FLOOR       = -(2 ** (msdla_pkg::POS_W - 1));
  localparam int LAG_TOP         = 2 ** msdla_pkg::LAG_W - 1;
  localparam int FS_TOP          = 2 ** msdla_pkg::FS_W - 1;
  localparam logic [msdla_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [msdla_pkg::ADDR_W-1:0] paddr;
  logic [msdla_pkg::DATA_W-1:0] pwdata;
  logic [msdla_pkg::DATA_W-1:0] prdata;
  logic                         pready;

  msdla_in_if  in_ch ();
  msdla_out_if out_ch ();

  int mismatches;
  int pending;
  int cycles = 0;
  int items_sent;
  int stall_left;
  int walk_pos;
  bit steady;
  bit hold_off_req;

  always #4 clk_i = ~clk_i;

  msd_lag_accumulator_core #(
    .MAX_SAMPLES   (MAX_SAMPLES),
    .POSITION_BOUND(POSITION_BOUND)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  msdla_scoreboard #(
    .MAX_SAMPLES   (MAX_SAMPLES),
    .POSITION_BOUND(POSITION_BOUND)
  ) msd_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(12, 40))
                                       : int'($urandom_range(1, 3));
  endfunction

  function automatic int next_position(input int from);
    int p;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) p = int'($urandom_range(0, 4095)) + POS_FLOOR;
    else if (pick == 1) p = $urandom_range(0, 1) ? int'($urandom_range(1000, POS_TOP))
                                                 : -int'($urandom_range(1000, -POS_FLOOR));
    else p = from + int'($urandom_range(0, 8)) - 4;
    if (p > POS_TOP) p = POS_TOP;
    if (p < POS_FLOOR) p = POS_FLOOR;
    return p;
  endfunction

  function automatic int pick_lag(input int len);
    if (len > 0 && $urandom_range(0, 4) != 0) return int'($urandom_range(0, len - 1));
    return int'($urandom_range(0, LAG_TOP));
  endfunction

  function automatic int history_len();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 0;
    if (pick == 1) return int'($urandom_range(25, 40));
    return int'($urandom_range(1, 24));
  endfunction

  // Entered and left at a falling edge; valid stays high for the caller's next item.
  task automatic send_item(input logic [msdla_pkg::KIND_W-1:0] kind, input int pos,
                           input int lag);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_len()) @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.position <= msdla_pkg::POS_W'(pos);
    in_ch.lag      <= msdla_pkg::LAG_W'(lag);
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  task automatic write_reg(input msdla_pkg::reg_idx_e idx, input int value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= msdla_pkg::ADDR_W'(int'(idx) * 4);
    pwdata  <= msdla_pkg::DATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(input bit mode, input int spacing);
    write_reg(msdla_pkg::REG_SPACING_MODE, mode);
    write_reg(msdla_pkg::REG_FIXED_SPACING, spacing);
  endtask

  task automatic run_history(input int len);
    walk_pos = int'($urandom_range(0, 40)) - 20;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_item(msdla_pkg::KIND_READ, int'($urandom_range(0, 4095)), pick_lag(i));
      if ($urandom_range(0, 31) == 0)
        send_item(KIND_UNUSED, int'($urandom_range(0, 4095)), int'($urandom_range(0, LAG_TOP)));
      walk_pos = next_position(walk_pos);
      send_item(msdla_pkg::KIND_LOAD, walk_pos, int'($urandom_range(0, LAG_TOP)));
    end
    send_item(msdla_pkg::KIND_ACCUM, int'($urandom_range(0, 4095)),
              int'($urandom_range(0, LAG_TOP)));
    repeat ($urandom_range(2, 6))
      send_item(msdla_pkg::KIND_READ, int'($urandom_range(0, 4095)), pick_lag(len));
  endtask

  // The trailing read cannot pass an accumulate, so an empty queue means idle.
  task automatic drain_results();
    send_item(msdla_pkg::KIND_READ, int'($urandom_range(0, 4095)),
              int'($urandom_range(0, LAG_TOP)));
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (steady || $urandom_range(0, 4) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left = gap_len() - 1;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.kind     = msdla_pkg::KIND_LOAD;
    in_ch.position = '0;
    in_ch.lag      = '0;
    steady         = 1'b1;
    hold_off_req   = 1'b0;
    items_sent     = 0;
    walk_pos       = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: clamping at both bounds, the unused kind, an empty accumulate.
    configure(1'b1, 1);
    send_item(msdla_pkg::KIND_LOAD, POSITION_BOUND, LAG_TOP);
    send_item(msdla_pkg::KIND_LOAD, -POSITION_BOUND, 0);
    send_item(msdla_pkg::KIND_LOAD, POS_TOP, LAG_TOP);
    send_item(msdla_pkg::KIND_LOAD, POS_FLOOR, 0);
    send_item(msdla_pkg::KIND_LOAD, 0, LAG_TOP);
    send_item(msdla_pkg::KIND_LOAD, POSITION_BOUND + 1, 0);
    send_item(msdla_pkg::KIND_LOAD, -POSITION_BOUND - 1, 0);
    send_item(msdla_pkg::KIND_LOAD, 7, 0);
    send_item(KIND_UNUSED, POS_FLOOR, LAG_TOP);
    send_item(msdla_pkg::KIND_ACCUM, POS_TOP, LAG_TOP);
    for (int lag = 0; lag < 8; lag++) send_item(msdla_pkg::KIND_READ, 0, lag);
    send_item(msdla_pkg::KIND_READ, POS_FLOOR, LAG_TOP);
    send_item(msdla_pkg::KIND_ACCUM, 0, 0);
    send_item(msdla_pkg::KIND_READ, 0, 1);
    drain_results();

    for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
      steady = (ph % 4 == 3);
      if (ph == 2) begin
        // one full trajectory with overflowing loads; lag spacing keeps it short
        configure(1'b0, int'($urandom_range(1, 1024)));
        run_history(MAX_SAMPLES + 6);
      end else begin
        case (ph % 5)
          0: configure(1'b0, int'($urandom_range(0, FS_TOP)));
          1: configure(1'b1, 0);
          2: configure(1'b1, 1);
          3: configure(1'b1, 1024);
          default: configure(1'b1, $urandom_range(0, 1) ? FS_TOP : int'($urandom_range(2, 9)));
        endcase
        repeat ($urandom_range(2, 4)) run_history(history_len());
        if (ph == 1) begin
          // hold the result side off while reads pile up behind it
          hold_off_req = 1'b1;
          repeat (12)
            send_item(msdla_pkg::KIND_READ, int'($urandom_range(0, 4095)),
                      int'($urandom_range(0, 40)));
        end
      end
      drain_results();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
